// File: rtl/core/gap_buffer_text_store_macros.svh
// Assertion macros for the gap buffer text store RTL.
`ifndef GAP_BUFFER_TEXT_STORE_MACROS_SVH
`define GAP_BUFFER_TEXT_STORE_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition at every rising clock edge outside reset.
`define GBTS_ASSERT(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Check that a consequent holds in the cycle of its antecedent.
`define GBTS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define GBTS_ASSERT(lbl, clk, rst, cond, msg)
`define GBTS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: rtl/core/gbts_pkg.sv
// Types and constants of the gap buffer text store.
`default_nettype none
package gbts_pkg;

  localparam int unsigned TEXT_W   = 11;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 24;
  localparam int unsigned S_PAD_W  = S_DATA_W - (2 * TEXT_W + CHAR_W);
  localparam int unsigned M_PAD_W  = M_DATA_W - (TEXT_W + CHAR_W);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_READ   = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MOVE,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [TEXT_W-1:0]  position;
    logic [CHAR_W-1:0]  insert_char;
    logic [TEXT_W-1:0]  remove_count;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  read_char;
    stat_t              status;
    logic [TEXT_W-1:0]  text_length;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/core/gap_buffer_text_store.sv
// Gap buffer text store: stream ports, byte memory and request sequencer.
`default_nettype none
// One request in, one result out. The text sits in a single byte memory of
// CAPACITY entries with the gap in between; no clearing pass runs after reset.
// A rejected request goes from the check state straight to the done state,
// a read passes through the read state, and an insert or a remove through
// the move state, which shifts the gap to the position before it edits: the
// memory's single write port copies one byte per cycle, so the gap distance
// sets the latency. One request is in work at a time; the next is taken in
// the cycle after the current result has entered the output register. A full
// output register that is not being drained holds the finished request back.
module gap_buffer_text_store #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // position [10:0], insert_char [18:11], remove_count [29:19], zero [31:30]
  input  wire logic [gbts_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // req_type [1:0]
  input  wire logic [1:0]                      s_axis_tuser,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // read_char [7:0], text_length [18:8], zero [23:19]
  output      logic [gbts_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // status [1:0]
  output      logic [1:0]                      m_axis_tuser
);
  import gbts_pkg::*;

  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  req_t              in_req;
  res_t              out_res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [CHAR_W-1:0] ram_rdata;

  // Unpack the request transaction
  always_comb begin
    in_req.req_type     = req_type_t'(s_axis_tuser);
    in_req.position     = s_axis_tdata[TEXT_W-1:0];
    in_req.insert_char  = s_axis_tdata[TEXT_W+CHAR_W-1:TEXT_W];
    in_req.remove_count = s_axis_tdata[2*TEXT_W+CHAR_W-1:TEXT_W+CHAR_W];
  end

  // Pack the result transaction
  assign m_axis_tdata = {{M_PAD_W{1'b0}}, out_res.text_length, out_res.read_char};
  assign m_axis_tuser = out_res.status;

  gbts_ctrl #(
    .CAPACITY (CAPACITY),
    .PW       (PW),
    .AW       (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_req    (in_req),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  gbts_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule
`default_nettype wire

// File: rtl/core/gbts_ram.sv
// Byte memory with one write port and one registered read port.
`default_nettype none
module gbts_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [gbts_pkg::CHAR_W-1:0] wdata,
  input  wire logic [AW-1:0]             raddr,
  output      logic [gbts_pkg::CHAR_W-1:0] rdata
);
  import gbts_pkg::*;

  logic [CHAR_W-1:0] mem [DEPTH];

  // Write one byte per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/gbts_ctrl.sv
// Request sequencer: checks, gap moves, edits and the result register.
`default_nettype none
`include "gap_buffer_text_store_macros.svh"
module gbts_ctrl #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned PW       = 11,
  parameter int unsigned AW       = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire gbts_pkg::req_t              in_req,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      gbts_pkg::res_t              out_res,
  output      logic                        ram_we,
  output      logic [AW-1:0]               ram_waddr,
  output      logic [gbts_pkg::CHAR_W-1:0] ram_wdata,
  output      logic [AW-1:0]               ram_raddr,
  input  wire logic [gbts_pkg::CHAR_W-1:0] ram_rdata
);
  import gbts_pkg::*;

  // Compare width covers both the text fields and the pointers
  localparam int unsigned CW = (PW > TEXT_W) ? PW : TEXT_W;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
  localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

  state_t        state, state_next;
  logic [PW-1:0] gs, gs_next;
  logic [PW-1:0] ge, ge_next;
  logic [PW-1:0] cnt, cnt_next;
  logic          pend, pend_next;
  logic [AW-1:0] pend_addr, pend_addr_next;
  logic          out_valid_next;
  req_t          req, req_next;
  logic [PW-1:0] tgt, tgt_next;
  logic [PW-1:0] rm_len, rm_len_next;
  res_t          rbuf, rbuf_next;
  res_t          out_res_next;

  logic [CW-1:0] pos_w, cnt_w, rc_w, gs_w, ge_w, avail_w, len_w, rd_addr_w;

  assign pos_w     = CW'(req.position);
  assign rc_w      = CW'(req.remove_count);
  assign cnt_w     = CW'(cnt);
  assign gs_w      = CW'(gs);
  assign ge_w      = CW'(ge);
  assign avail_w   = cnt_w - pos_w;
  assign len_w     = (rc_w > avail_w) ? avail_w : rc_w;
  assign rd_addr_w = (pos_w < gs_w) ? pos_w : (ge_w + pos_w - gs_w);

  // Next state, memory accesses and result
  always_comb begin
    state_next     = state;
    gs_next        = gs;
    ge_next        = ge;
    cnt_next       = cnt;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    req_next       = req;
    tgt_next       = tgt;
    rm_len_next    = rm_len;
    rbuf_next      = rbuf;
    out_res_next   = out_res;
    out_valid_next = out_valid && !out_ready;
    in_ready       = (state == ST_IDLE);
    ram_we         = 1'b0;
    ram_waddr      = pend_addr;
    ram_wdata      = ram_rdata;
    ram_raddr      = '0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          req_next   = in_req;
          state_next = ST_CHECK;
        end
      end

      ST_CHECK: begin
        rbuf_next.read_char   = '0;
        rbuf_next.status      = STAT_OK;
        rbuf_next.text_length = '0;
        tgt_next              = pos_w[PW-1:0];
        rm_len_next           = len_w[PW-1:0];
        state_next            = ST_DONE;
        case (req.req_type)
          REQ_INSERT: begin
            if (pos_w > cnt_w) begin
              rbuf_next.status = STAT_RANGE;
            end else if (cnt_w >= CAP_W) begin
              rbuf_next.status = STAT_FULL;
            end else begin
              state_next = ST_MOVE;
            end
          end
          REQ_REMOVE: begin
            if (pos_w >= cnt_w) begin
              rbuf_next.status = STAT_RANGE;
            end else begin
              state_next = ST_MOVE;
            end
          end
          REQ_READ: begin
            if (pos_w >= cnt_w) begin
              rbuf_next.status = STAT_RANGE;
            end else begin
              ram_raddr  = rd_addr_w[AW-1:0];
              state_next = ST_READ;
            end
          end
          default: begin
          end
        endcase
      end

      ST_MOVE: begin
        // Complete the copy issued last cycle
        if (pend) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr;
          ram_wdata = ram_rdata;
          pend_next = 1'b0;
        end
        if (gs > tgt) begin
          // Move one byte from below the gap to its top
          ram_raddr      = AW'(gs - 1'b1);
          pend_addr_next = AW'(ge - 1'b1);
          pend_next      = 1'b1;
          gs_next        = gs - 1'b1;
          ge_next        = ge - 1'b1;
        end else if ((gs < tgt) && (ge < CAP_P)) begin
          // Move one byte from above the gap to its bottom
          ram_raddr      = ge[AW-1:0];
          pend_addr_next = gs[AW-1:0];
          pend_next      = 1'b1;
          gs_next        = gs + 1'b1;
          ge_next        = ge + 1'b1;
        end else if (!pend) begin
          // Gap in place: apply the edit
          if (req.req_type == REQ_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = gs[AW-1:0];
            ram_wdata = req.insert_char;
            gs_next   = gs + 1'b1;
            cnt_next  = cnt + 1'b1;
          end else begin
            ge_next  = ge + rm_len;
            cnt_next = cnt - rm_len;
          end
          state_next = ST_DONE;
        end
      end

      ST_READ: begin
        rbuf_next.read_char = ram_rdata;
        state_next          = ST_DONE;
      end

      ST_DONE: begin
        // Hand the result over once the output register is free
        if (!out_valid || out_ready) begin
          out_res_next.read_char   = rbuf.read_char;
          out_res_next.status      = rbuf.status;
          out_res_next.text_length = cnt_w[TEXT_W-1:0];
          out_valid_next           = 1'b1;
          state_next               = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      gs        <= '0;
      ge        <= CAP_P;
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      gs        <= gs_next;
      ge        <= ge_next;
      cnt       <= cnt_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_addr <= pend_addr_next;
    req       <= req_next;
    tgt       <= tgt_next;
    rm_len    <= rm_len_next;
    rbuf      <= rbuf_next;
    out_res   <= out_res_next;
  end

  `GBTS_ASSERT(a_gap_size, clk, rst, (ge - gs) == (CAP_P - cnt), "gap size disagrees with count")
  `GBTS_ASSERT(a_count_max, clk, rst, (cnt <= CAP_P) && (ge <= CAP_P), "pointer beyond capacity")
  `GBTS_ASSERT_IMPL(a_idle_quiet, clk, rst, state == ST_IDLE, !ram_we && !pend, "write while idle")
  `GBTS_ASSERT_IMPL(a_edit_clean, clk, rst, (state == ST_MOVE) && (state_next == ST_DONE), !pend, "edit before copy drained")

endmodule
`default_nettype wire
